// ===== rtl/core/mmws_pkg.sv =====
package mmws_pkg;

    localparam int NUM_DIMS  = 3;
    localparam int NUM_SUMS  = 2 * NUM_DIMS;
    localparam int SUM_W     = 48;
    localparam int MASS_W    = 24;
    localparam int PROD_W    = 36;

    // Order of the weighted sums inside one slot of the sum memory
    localparam logic [2:0] SUM_PX = 3'd0;
    localparam logic [2:0] SUM_PY = 3'd1;
    localparam logic [2:0] SUM_PZ = 3'd2;
    localparam logic [2:0] SUM_VX = 3'd3;
    localparam logic [2:0] SUM_VY = 3'd4;
    localparam logic [2:0] SUM_VZ = 3'd5;

    typedef struct packed {
        logic [15:0]        mol_num;
        logic [15:0]        atom_mass;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic signed [19:0] vel_x;
        logic signed [19:0] vel_y;
        logic signed [19:0] vel_z;
        logic               last_atom;
    } t_atom;

    typedef struct packed {
        logic [15:0]              out_molecule_id;
        logic [MASS_W-1:0]        total_mass;
        logic signed [SUM_W-1:0]  wsum_pos_x;
        logic signed [SUM_W-1:0]  wsum_pos_y;
        logic signed [SUM_W-1:0]  wsum_pos_z;
        logic signed [SUM_W-1:0]  wsum_vel_x;
        logic signed [SUM_W-1:0]  wsum_vel_y;
        logic signed [SUM_W-1:0]  wsum_vel_z;
        logic                     table_overflow;
        logic                     last_molecule;
    } t_result;

endpackage

// ===== rtl/core/molecule_mass_weighted_sum.sv =====
// Busy stays high while the block scans the ids, allocates a slot and accumulates the six sums
// for an atom; an atom that finds the table full is dropped. A new atom is taken only in idle,
// so the block cannot take the next atom before it is through with the last one.
// A last atom then unloads every used slot; each result word shows for exactly one cycle
// (the final one in the first cycle with busy low) and the receiver cannot stall. The id scan
// runs one slot a cycle, and one shared multiply/add unit forms all six sums in turn.
// Reset (i_rst_n low, synchronous) empties the table; no clearing pass is needed.
module molecule_mass_weighted_sum
    import mmws_pkg::*;
#(
    parameter int MAX_MOLECULES = 64
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_atom   i_atom,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    // Slot index, slot count and sum memory address widths
    localparam int SW    = (MAX_MOLECULES > 1) ? $clog2(MAX_MOLECULES) : 1;
    localparam int CW    = $clog2(MAX_MOLECULES + 1);
    localparam int DEPTH = MAX_MOLECULES * NUM_SUMS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ALLOC,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_OUT_RD
    } t_state;

    t_state r_state;

    // Latched atom word and sequencer bookkeeping
    t_atom         r_in;
    logic [CW-1:0] r_used;
    logic          r_ovf;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_cmp_idx;
    logic          r_cmp_v;
    logic [SW-1:0] r_slot;
    logic          r_new;
    logic [2:0]    r_k;

    // Table storage: ids, masses and the six weighted sums per slot
    logic [15:0]             r_id_mem   [MAX_MOLECULES];
    logic [MASS_W-1:0]       r_mass_mem [MAX_MOLECULES];
    logic signed [SUM_W-1:0] r_sum_mem  [DEPTH];
    logic [15:0]             r_id_q;
    logic [MASS_W-1:0]       r_mass_q;
    logic signed [SUM_W-1:0] r_sum_q;

    // Result assembly
    logic signed [SUM_W-1:0] r_sh [NUM_SUMS];
    logic [15:0]             r_out_id;
    logic [MASS_W-1:0]       r_out_mass;
    logic                    r_out_ovf;
    logic                    r_out_last;
    logic                    r_out_v;

    // Address and datapath signals
    logic [SW-1:0]           mass_addr;
    logic [AW-1:0]           sum_base;
    logic [AW-1:0]           sum_addr;
    logic                    id_we;
    logic                    sum_we;
    logic                    mass_we;
    logic                    id_hit;
    logic                    scan_end;
    logic                    slot_last;
    logic                    table_full;
    logic signed [19:0]      coord;
    logic signed [SUM_W-1:0] acc_old;
    logic signed [SUM_W-1:0] acc_new;
    logic [MASS_W:0]         mass_wide;
    logic [MASS_W-1:0]       mass_new;

    // Output slot comes from the scan counter, accumulation slot from the found slot
    assign mass_addr  = (r_state == ST_OUT_RD) ? r_idx : r_slot;
    assign sum_base   = AW'(mass_addr) * AW'(NUM_SUMS);
    assign sum_addr   = sum_base + AW'(r_k);

    assign id_hit     = r_cmp_v && (r_id_q == r_in.mol_num);
    assign scan_end   = r_cmp_v && ((CW'(r_cmp_idx) + CW'(1)) == r_used);
    assign slot_last  = (CW'(r_idx) + CW'(1)) == r_used;
    assign table_full = r_used == CW'(MAX_MOLECULES);

    assign id_we   = (r_state == ST_ALLOC) && !table_full;
    assign sum_we  = (r_state == ST_ACC_WR);
    assign mass_we = (r_state == ST_ACC_WR) && (r_k == SUM_PX);

    always_comb begin
        case (r_k)
            SUM_PX:  coord = r_in.pos_x;
            SUM_PY:  coord = r_in.pos_y;
            SUM_PZ:  coord = r_in.pos_z;
            SUM_VX:  coord = r_in.vel_x;
            SUM_VY:  coord = r_in.vel_y;
            SUM_VZ:  coord = r_in.vel_z;
            default: coord = '0;
        endcase
    end

    // A freshly allocated slot starts from zero, whatever the memory holds
    assign acc_old = r_new ? '0 : r_sum_q;

    mmws_mac u_mac (
        .i_clk   (i_clk),
        .i_load  (r_state == ST_ACC_RD),
        .i_mass  (r_in.atom_mass),
        .i_coord (coord),
        .i_acc   (acc_old),
        .o_sum   (acc_new)
    );

    // Mass sum saturates at the top of its unsigned range
    assign mass_wide = {1'b0, (r_new ? {MASS_W{1'b0}} : r_mass_q)} + (MASS_W+1)'(r_in.atom_mass);
    assign mass_new  = mass_wide[MASS_W] ? '1 : mass_wide[MASS_W-1:0];

    // Memories: one write port and one registered read port each
    always_ff @(posedge i_clk) begin
        if (id_we) begin
            r_id_mem[SW'(r_used)] <= r_in.mol_num;
        end
        r_id_q <= r_id_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (mass_we) begin
            r_mass_mem[r_slot] <= mass_new;
        end
        r_mass_q <= r_mass_mem[mass_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sum_mem[sum_addr] <= acc_new;
        end
        r_sum_q <= r_sum_mem[sum_addr];
    end

    // Sequencer: scan ids, allocate, accumulate six sums, then unload the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_cmp_v  <= 1'b0;
            r_k      <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_in    <= i_atom;
                        r_idx   <= '0;
                        r_cmp_v <= 1'b0;
                        // an empty table has nothing to scan
                        r_state <= (r_used == '0) ? ST_ALLOC : ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    r_cmp_v   <= 1'b1;
                    r_cmp_idx <= r_idx;
                    r_idx     <= r_idx + SW'(1);
                    if (id_hit) begin
                        r_slot  <= r_cmp_idx;
                        r_new   <= 1'b0;
                        r_k     <= SUM_PX;
                        r_state <= ST_ACC_RD;
                    end else if (scan_end) begin
                        r_state <= ST_ALLOC;
                    end
                end
                ST_ALLOC: begin
                    if (!table_full) begin
                        r_slot  <= SW'(r_used);
                        r_new   <= 1'b1;
                        r_used  <= r_used + CW'(1);
                        r_k     <= SUM_PX;
                        r_state <= ST_ACC_RD;
                    end else begin
                        // drop the atom, flag it, still honor the run end
                        r_ovf <= 1'b1;
                        if (r_in.last_atom) begin
                            r_idx   <= '0;
                            r_k     <= '0;
                            r_state <= ST_OUT_RD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ACC_RD: begin
                    r_state <= ST_ACC_WR;
                end
                ST_ACC_WR: begin
                    if (r_k == SUM_VZ) begin
                        if (r_in.last_atom) begin
                            r_idx   <= '0;
                            r_k     <= '0;
                            r_state <= ST_OUT_RD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= ST_ACC_RD;
                    end
                end
                ST_OUT_RD: begin
                    if (r_k != '0) begin
                        r_sh[NUM_SUMS-1] <= r_sum_q;
                        for (int i = 0; i < NUM_SUMS - 1; i++) begin
                            r_sh[i] <= r_sh[i+1];
                        end
                    end
                    if (r_k == 3'd1) begin
                        r_out_id   <= r_id_q;
                        r_out_mass <= r_mass_q;
                    end
                    if (r_k == 3'(NUM_SUMS)) begin
                        // all six sums captured: strobe the result word
                        r_out_v    <= 1'b1;
                        r_out_ovf  <= r_ovf;
                        r_out_last <= slot_last;
                        r_k        <= '0;
                        if (slot_last) begin
                            r_used  <= '0;
                            r_ovf   <= 1'b0;
                            r_idx   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + SW'(1);
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_out_v;

    assign o_result.out_molecule_id = r_out_id;
    assign o_result.total_mass      = r_out_mass;
    assign o_result.wsum_pos_x      = r_sh[SUM_PX];
    assign o_result.wsum_pos_y      = r_sh[SUM_PY];
    assign o_result.wsum_pos_z      = r_sh[SUM_PZ];
    assign o_result.wsum_vel_x      = r_sh[SUM_VX];
    assign o_result.wsum_vel_y      = r_sh[SUM_VY];
    assign o_result.wsum_vel_z      = r_sh[SUM_VZ];
    assign o_result.table_overflow  = r_out_ovf;
    assign o_result.last_molecule   = r_out_last;

    // Slot count never passes the table size
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_MOLECULES))
        else $error("slot count beyond table size");

    // Result strobes are never back to back, as the capture of six sums separates them
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back to back result strobes");

    // A result that is not the final one leaves the block still unloading
    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last_molecule) |-> o_busy)
        else $error("unload stopped before final result");

    // Final result leaves an empty table
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_molecule) |-> (r_used == '0 && !r_ovf))
        else $error("table not cleared at run end");

endmodule

// ===== rtl/core/mmws_mac.sv =====
module mmws_mac
    import mmws_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic [15:0]             i_mass,
    input  logic signed [19:0]      i_coord,
    input  logic signed [SUM_W-1:0] i_acc,
    output logic signed [SUM_W-1:0] o_sum
);

    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W:0]    sum_wide;

    assign prod_full = $signed({1'b0, i_mass}) * i_coord;

    // hold the product for the add in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= prod_full;
        end
    end

    assign sum_wide = {i_acc[SUM_W-1], i_acc} + (SUM_W+1)'(r_prod);

    // clamp to the 48 bit signed range
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            o_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            o_sum = sum_wide[SUM_W-1:0];
        end
    end

endmodule
